[rtl/rpne_pkg.sv]
// Shared types and constants for the postfix expression evaluator.
// No dependencies; every other file in rtl/ refers to this package.
package rpne_pkg;

	localparam int DATA_W          = 32;
	localparam int SYM_W           = 8;
	localparam int STACK_DEPTH_DEF = 32;
	localparam int DIV_CNT_W       = $clog2(DATA_W + 1);

	localparam logic [SYM_W-1:0] SYM_MUL  = 8'd42;
	localparam logic [SYM_W-1:0] SYM_ADD  = 8'd43;
	localparam logic [SYM_W-1:0] SYM_SUB  = 8'd45;
	localparam logic [SYM_W-1:0] SYM_DIV  = 8'd47;
	localparam logic [SYM_W-1:0] SYM_ZERO = 8'd48;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_UNDER   = 2'd1,
		STATUS_OVER    = 2'd2,
		STATUS_DIVZERO = 2'd3
	} status_t;

	// What a stack cell loads next: hold, the neighbor above (push / new top),
	// or the neighbor below (pop).
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_RAISE
	} cell_op_t;

	typedef enum logic [1:0] {
		PS_IDLE,
		PS_EXEC,
		PS_DIV,
		PS_EMIT
	} eval_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/rpne_if.sv]
// Valid/ready channel interfaces for the evaluator's input and result words.
// Depends on rpne_pkg for field widths.
interface rpne_in_if;
	logic                         valid;
	logic                         ready;
	logic [rpne_pkg::SYM_W-1:0]   symbol;
	logic                         end_of_expression;

	modport source (output valid, output symbol, output end_of_expression, input ready);
	modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

interface rpne_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [rpne_pkg::DATA_W-1:0]  result_value;
	logic [1:0]                          status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink   (input valid, input result_value, input status, output ready);
endinterface

[rtl/rpne_cell.sv]
// One operand stack entry; loads from its upper or lower neighbor or holds.
// Depends on rpne_pkg.
module rpne_cell (
	input  logic                          clk,
	input  rpne_pkg::cell_op_t            cmd,
	input  logic [rpne_pkg::DATA_W-1:0]   up_val,
	input  logic [rpne_pkg::DATA_W-1:0]   down_val,
	output logic [rpne_pkg::DATA_W-1:0]   val_q
);

	always_ff @(posedge clk) begin
		unique case (cmd)
			rpne_pkg::CELL_LOAD:  val_q <= up_val;
			rpne_pkg::CELL_RAISE: val_q <= down_val;
			default:              val_q <= val_q;
		endcase
	end

endmodule

[rtl/rpne_div.sv]
// Radix-2 restoring divider, signed, truncating toward zero, one bit a cycle.
// Depends on rpne_pkg. Divisor must be nonzero when start is raised.
module rpne_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rpne_pkg::DATA_W-1:0]   dividend,
	input  logic [rpne_pkg::DATA_W-1:0]   divisor,
	output rpne_pkg::div_stat_t           stat,
	output logic [rpne_pkg::DATA_W-1:0]   quotient
);

	localparam int W = rpne_pkg::DATA_W;

	logic                            busy_q;
	logic                            done_q;
	logic [rpne_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [W-1:0]                    rem_q;
	logic [W-1:0]                    quo_q;
	logic [W-1:0]                    mb_q;
	logic                            neg_q;

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic [W-1:0] ma;
	logic [W-1:0] mb;

	assign ma      = dividend[W-1] ? (W'(0) - dividend) : dividend;
	assign mb      = divisor[W-1] ? (W'(0) - divisor) : divisor;
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rpne_pkg::DIV_CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rpne_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= ma;
			mb_q  <= mb;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			// keep the trial difference when it does not borrow
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

[rtl/postfix_expression_evaluator_unit.sv]
// Postfix evaluator top level: control, row of stack cells, divider, result register.
// Depends on rpne_pkg, rpne_if, rpne_cell and rpne_div.
//
// Usage:
//   expr   - input words (symbol, end_of_expression), valid/ready. A symbol
//            that is not * + - / pushes symbol - 48; an operator pops two
//            entries and pushes the 32-bit wrapping result.
//   result - one word per expression (result_value, status), valid/ready,
//            sent after the word marked end_of_expression.
// Sequencing:
//   A push, +, - or * passes through EXEC before ready returns in IDLE.
//   A / by a nonzero divisor also waits in DIV for the one-bit-per-cycle divider.
//   The last word of an expression goes on to EMIT, which waits for a free
//   result register and loads it; that register drives result.
// The stack is a row of cells with the top at cell 0; a push shifts every
// cell down by one, an operator shifts them up and loads the new top.
// Reset empties the stack, clears the error and drops any pending result.
// A stalled receiver holds the result register; the next expression's words
// are still taken until its own last word needs the result register.
module postfix_expression_evaluator_unit #(
	parameter int STACK_DEPTH = rpne_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rpne_in_if.sink           expr,
	rpne_out_if.source        result
);

	localparam int W  = rpne_pkg::DATA_W;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	rpne_pkg::eval_state_t     state_q, state_d;
	logic [rpne_pkg::SYM_W-1:0] sym_q;
	logic                      last_q;
	logic [CW-1:0]             count_q, count_d;
	rpne_pkg::status_t         err_q, err_d;

	logic                      out_valid_q;
	logic [W-1:0]              out_value_q;
	rpne_pkg::status_t         out_status_q;

	logic [W-1:0]              vals [STACK_DEPTH];
	rpne_pkg::cell_op_t        cmd [STACK_DEPTH];
	logic [W-1:0]              new_top;
	logic                      do_push, do_pop, div_start, emit, slot_free, is_op;
	logic [W-1:0]              push_val, product;

	rpne_pkg::div_stat_t       div_stat;
	logic [W-1:0]              quotient;

	assign is_op = (sym_q == rpne_pkg::SYM_MUL) || (sym_q == rpne_pkg::SYM_ADD) ||
		(sym_q == rpne_pkg::SYM_SUB) || (sym_q == rpne_pkg::SYM_DIV);
	assign push_val  = W'(sym_q) - W'(rpne_pkg::SYM_ZERO);
	assign product   = vals[1] * vals[0];
	assign slot_free = !out_valid_q || result.ready;
	assign expr.ready = (state_q == rpne_pkg::PS_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpne_pkg::PS_IDLE: begin
				if (expr.valid) state_d = rpne_pkg::PS_EXEC;
			end
			rpne_pkg::PS_EXEC: begin
				if (div_start)   state_d = rpne_pkg::PS_DIV;
				else if (last_q) state_d = rpne_pkg::PS_EMIT;
				else             state_d = rpne_pkg::PS_IDLE;
			end
			rpne_pkg::PS_DIV: begin
				if (div_stat.done) state_d = last_q ? rpne_pkg::PS_EMIT : rpne_pkg::PS_IDLE;
			end
			rpne_pkg::PS_EMIT: begin
				if (slot_free) state_d = rpne_pkg::PS_IDLE;
			end
			default: state_d = rpne_pkg::PS_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		do_push   = 1'b0;
		do_pop    = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		new_top   = push_val;
		count_d   = count_q;
		err_d     = err_q;
		unique case (state_q)
			rpne_pkg::PS_EXEC: begin
				if (err_q == rpne_pkg::STATUS_OK) begin
					if (!is_op) begin
						if (count_q == CW'(STACK_DEPTH)) begin
							err_d = rpne_pkg::STATUS_OVER;
						end else begin
							do_push = 1'b1;
							count_d = count_q + 1'b1;
						end
					end else if (count_q < CW'(2)) begin
						err_d = rpne_pkg::STATUS_UNDER;
					end else begin
						unique case (sym_q)
							rpne_pkg::SYM_MUL: begin
								new_top = product;
								do_pop  = 1'b1;
							end
							rpne_pkg::SYM_ADD: begin
								new_top = vals[1] + vals[0];
								do_pop  = 1'b1;
							end
							rpne_pkg::SYM_SUB: begin
								new_top = vals[1] - vals[0];
								do_pop  = 1'b1;
							end
							default: begin
								if (vals[0] == '0) err_d = rpne_pkg::STATUS_DIVZERO;
								else               div_start = 1'b1;
							end
						endcase
						if (do_pop) count_d = count_q - 1'b1;
					end
				end
			end
			rpne_pkg::PS_DIV: begin
				if (div_stat.done) begin
					new_top = quotient;
					do_pop  = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			rpne_pkg::PS_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					count_d = '0;
					err_d   = rpne_pkg::STATUS_OK;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if (do_push)                cmd[i] = rpne_pkg::CELL_LOAD;
			else if (do_pop && i == 0)  cmd[i] = rpne_pkg::CELL_LOAD;
			else if (do_pop)            cmd[i] = rpne_pkg::CELL_RAISE;
			else                        cmd[i] = rpne_pkg::CELL_HOLD;
		end
	end

	for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
		logic [W-1:0] up_val;
		logic [W-1:0] down_val;
		if (g == 0) begin : g_top
			assign up_val = new_top;
		end else begin : g_mid
			assign up_val = vals[g-1];
		end
		if (g == STACK_DEPTH - 1) begin : g_bot
			assign down_val = '0;
		end else begin : g_lower
			assign down_val = vals[g+1];
		end
		rpne_cell u_cell (
			.clk      (clk),
			.cmd      (cmd[g]),
			.up_val   (up_val),
			.down_val (down_val),
			.val_q    (vals[g])
		);
	end

	rpne_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (vals[1]),
		.divisor  (vals[0]),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpne_pkg::PS_IDLE;
			count_q     <= '0;
			err_q       <= rpne_pkg::STATUS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q   <= err_d;
			if (emit)              out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (expr.valid && expr.ready) begin
			sym_q  <= expr.symbol;
			last_q <= expr.end_of_expression;
		end
		if (emit) begin
			if (err_q != rpne_pkg::STATUS_OK) begin
				out_value_q  <= '0;
				out_status_q <= err_q;
			end else if (count_q == '0) begin
				out_value_q  <= '0;
				out_status_q <= rpne_pkg::STATUS_UNDER;
			end else begin
				out_value_q  <= vals[0];
				out_status_q <= rpne_pkg::STATUS_OK;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_value = out_value_q;
	assign result.status       = out_status_q;

endmodule
